// File: sv/led_matrix_quarter_scan_driver_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quarter-scan driver
// Property wrappers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_QUARTER_SCAN_DRIVER_ASSERT_SVH
`define LED_MATRIX_QUARTER_SCAN_DRIVER_ASSERT_SVH

// check cons in the same cycle as ante
`define LMQS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define LMQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lmqs_pkg.sv
// ----------------------------------------------------------------------------
// lmqs_pkg
// Shared types and constants of the quarter-scan driver.
// ----------------------------------------------------------------------------
package lmqs_pkg;

  localparam int ROW_W       = 4;
  localparam int COL_W       = 3;
  localparam int BYTE_W      = 8;
  localparam int GRP_W       = 2;
  localparam int FB_ROWS     = 16;
  localparam int FB_COLS     = 8;
  localparam int FB_DEPTH    = FB_ROWS * FB_COLS;
  localparam int ADDR_W      = ROW_W + COL_W;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = 1;
  localparam int CNT_W       = 2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [BYTE_W-1:0] BLANK_BYTE = 8'hFF;

  typedef struct packed {
    logic              is_tick;
    logic              wr_ok;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
  } fr_stat_t;

  typedef struct packed {
    logic             scanning;
    logic             last_issue;
    logic [GRP_W-1:0] grp;
  } bk_stat_t;

endpackage

// File: sv/lmqs_front.sv
// ----------------------------------------------------------------------------
// lmqs_front
// Accept input words, decode write or tick, range-check writes, and hold
// the decoded commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module lmqs_front #(
  parameter int PANEL_ROWS    = 16,
  parameter int PANEL_COLUMNS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // row[3:0], byte_column[6:4], pixel_byte[14:7], zero[15]
  input  logic [lmqs_pkg::IN_DATA_W-1:0]   in_tdata,
  // opcode[0]
  input  logic                             in_tuser,
  output logic                             q_valid,
  output lmqs_pkg::cmd_t                   q_cmd,
  input  logic                             q_pop,
  output lmqs_pkg::fr_stat_t               stat
);
  import lmqs_pkg::*;

  localparam int BYTES_PER_ROW = PANEL_COLUMNS / 8;

  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [BYTE_W-1:0] pix;
  cmd_t              cmd_in;
  logic              push;

  cmd_t              ent_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [PTR_W-1:0]  rp_r, rp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign row = in_tdata[ROW_W-1:0];
  assign col = in_tdata[ROW_W+COL_W-1:ROW_W];
  assign pix = in_tdata[ROW_W+COL_W+BYTE_W-1:ROW_W+COL_W];

  always_comb begin
    cmd_in.is_tick = (in_tuser == OP_TICK);
    cmd_in.wr_ok   = (int'(row) < PANEL_ROWS) && (int'(col) < BYTES_PER_ROW);
    cmd_in.addr    = {row, col};
    cmd_in.data    = pix;
  end

  assign in_tready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_cmd     = ent_r[rp_r];
  assign stat.cnt  = cnt_r;

  always_comb begin
    wp_nxt  = push ? wp_r + PTR_W'(1) : wp_r;
    rp_nxt  = q_pop ? rp_r + PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= cmd_in;
    end
  end

endmodule

// File: sv/lmqs_back.sv
// ----------------------------------------------------------------------------
// lmqs_back
// Execute queued commands: store frame buffer bytes, and sequence the scan
// reads of a tick through a read stage and an output register.
// ----------------------------------------------------------------------------
module lmqs_back #(
  parameter int PANEL_ROWS    = 16,
  parameter int PANEL_COLUMNS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  lmqs_pkg::cmd_t                   q_cmd,
  output logic                             q_pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // shift_byte[7:0], scan_group[9:8], zero[15:10]
  output logic [lmqs_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tlast,
  output lmqs_pkg::bk_stat_t               stat
);
  import lmqs_pkg::*;

  localparam int BPR  = PANEL_COLUMNS / 8;
  localparam int RB   = PANEL_ROWS / 4;
  localparam int CW   = (BPR > 1) ? $clog2(BPR) : 1;
  localparam int JW   = (RB > 1) ? $clog2(RB) : 1;
  localparam logic [CW-1:0] LAST_COL = CW'(BPR - 1);
  localparam logic [JW-1:0] TOP_J    = JW'(RB - 1);
  localparam int PAD_W = OUT_DATA_W - GRP_W - BYTE_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [JW-1:0]     j_r, j_nxt;
  logic [GRP_W-1:0]  grp_r, grp_nxt;

  logic              s1_v_r, s1_v_nxt;
  logic              s1_last_r;
  logic [GRP_W-1:0]  s1_grp_r;
  logic [BYTE_W-1:0] rd_data_r;
  logic              rd_vld_r;

  logic              out_v_r, out_v_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic [GRP_W-1:0]  out_grp_r;
  logic              out_last_r;

  logic [BYTE_W-1:0] mem [FB_DEPTH];
  logic [FB_DEPTH-1:0] vld_r;

  logic              s1_adv, out_adv, issue, last_issue, wr_en, rd_in;
  logic [31:0]       row_ext, col_ext;
  logic [ADDR_W-1:0] rd_addr;

  assign out_adv    = !out_v_r || out_tready;
  assign s1_adv     = !s1_v_r || out_adv;
  assign issue      = (state_r == ST_SCAN) && s1_adv;
  assign last_issue = issue && (j_r == '0) && (col_r == LAST_COL);
  assign q_pop      = (state_r == ST_IDLE) && q_valid;
  assign wr_en      = q_pop && !q_cmd.is_tick && q_cmd.wr_ok;

  assign row_ext = 32'({j_r, grp_r});
  assign col_ext = 32'(col_r);
  assign rd_in   = (row_ext < FB_ROWS) && (col_ext < FB_COLS);
  assign rd_addr = {row_ext[ROW_W-1:0], col_ext[COL_W-1:0]};

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    j_nxt     = j_r;
    grp_nxt   = grp_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop && q_cmd.is_tick) begin
          state_nxt = ST_SCAN;
          col_nxt   = '0;
          j_nxt     = TOP_J;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          if (j_r == '0) begin
            j_nxt = TOP_J;
            if (col_r == LAST_COL) begin
              state_nxt = ST_IDLE;
              grp_nxt   = grp_r + GRP_W'(1);
            end else begin
              col_nxt = col_r + CW'(1);
            end
          end else begin
            j_nxt = j_r - JW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign s1_v_nxt  = s1_adv ? issue : s1_v_r;
  assign out_v_nxt = out_adv ? s1_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= '0;
      j_r     <= '0;
      grp_r   <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      j_r     <= j_nxt;
      grp_r   <= grp_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[q_cmd.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[q_cmd.addr] <= q_cmd.data;
    end
    if (issue) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr] && rd_in;
      s1_last_r <= last_issue;
      s1_grp_r  <= grp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_byte_r <= rd_vld_r ? ~rd_data_r : ~BLANK_BYTE;
      out_grp_r  <= s1_grp_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_grp_r, out_byte_r};
  assign out_tlast  = out_last_r;

  assign stat.scanning   = (state_r == ST_SCAN);
  assign stat.last_issue = last_issue;
  assign stat.grp        = grp_r;

endmodule

// File: sv/led_matrix_quarter_scan_driver.sv
// ----------------------------------------------------------------------------
// led_matrix_quarter_scan_driver: a write word in range stores one frame buffer
// byte; a tick emits (PANEL_COLUMNS/8)*(PANEL_ROWS/4) bytes (32), one frame buffer
// read per byte, each through the read stage and the output register. Reset is
// synchronous, clears group to 0 and marks every frame buffer byte blank.
// ----------------------------------------------------------------------------
module led_matrix_quarter_scan_driver #(
  parameter int PANEL_ROWS    = 16,
  parameter int PANEL_COLUMNS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // row[3:0], byte_column[6:4], pixel_byte[14:7], zero[15]
  input  logic [lmqs_pkg::IN_DATA_W-1:0]   in_tdata,
  // opcode[0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // shift_byte[7:0], scan_group[9:8], zero[15:10]
  output logic [lmqs_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tlast
);
  import lmqs_pkg::*;

  logic     q_valid;
  cmd_t     q_cmd;
  logic     q_pop;
  fr_stat_t fr_stat;
  bk_stat_t bk_stat;

  lmqs_front #(
    .PANEL_ROWS   (PANEL_ROWS),
    .PANEL_COLUMNS(PANEL_COLUMNS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .stat     (fr_stat)
  );

  lmqs_back #(
    .PANEL_ROWS   (PANEL_ROWS),
    .PANEL_COLUMNS(PANEL_COLUMNS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .stat      (bk_stat)
  );

`include "led_matrix_quarter_scan_driver_assert.svh"

  `LMQS_ASSERT_NEXT(a_word_queued, in_tvalid && in_tready, fr_stat.cnt != '0, "accepted word not queued")
  `LMQS_ASSERT_NEXT(a_scan_ends, bk_stat.last_issue, !bk_stat.scanning, "scan runs past last byte")
  `LMQS_ASSERT_NEXT(a_grp_hold, !bk_stat.last_issue, bk_stat.grp == $past(bk_stat.grp), "group moved mid-scan")
  `LMQS_ASSERT_NOW(a_last_in_scan, bk_stat.last_issue, bk_stat.scanning, "last byte outside a scan")

endmodule
